@@ rtl/magma_block_cipher_macros.svh @@
// ----------------------------------------------------------------------------
// Magma cipher assertion macros
// Shared property shorthands for the cipher's concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef MAGMA_BLOCK_CIPHER_MACROS_SVH
`define MAGMA_BLOCK_CIPHER_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define MAGMA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define MAGMA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/magma_pkg.sv @@
// ----------------------------------------------------------------------------
// Magma cipher package
// Round count, stage payload type, S-box table and the round function.
// ----------------------------------------------------------------------------
`default_nettype none

package magma_pkg;

  localparam int ROUNDS    = 32;
  localparam int KEY_WORDS = 8;
  localparam int KEY_IDX_W = $clog2(KEY_WORDS);

  typedef logic [31:0] word_t;
  typedef word_t key_arr_t [KEY_WORDS];

  // Payload carried from one round stage to the next.
  typedef struct packed {
    logic  action;
    word_t a1;
    word_t a0;
  } stage_t;

  localparam logic [3:0] SBOX [8][16] = '{
    '{4'hc, 4'h4, 4'h6, 4'h2, 4'ha, 4'h5, 4'hb, 4'h9,
      4'he, 4'h8, 4'hd, 4'h7, 4'h0, 4'h3, 4'hf, 4'h1},
    '{4'h6, 4'h8, 4'h2, 4'h3, 4'h9, 4'ha, 4'h5, 4'hc,
      4'h1, 4'he, 4'h4, 4'h7, 4'hb, 4'hd, 4'h0, 4'hf},
    '{4'hb, 4'h3, 4'h5, 4'h8, 4'h2, 4'hf, 4'ha, 4'hd,
      4'he, 4'h1, 4'h7, 4'h4, 4'hc, 4'h9, 4'h6, 4'h0},
    '{4'hc, 4'h8, 4'h2, 4'h1, 4'hd, 4'h4, 4'hf, 4'h6,
      4'h7, 4'h0, 4'ha, 4'h5, 4'h3, 4'he, 4'h9, 4'hb},
    '{4'h7, 4'hf, 4'h5, 4'ha, 4'h8, 4'h1, 4'h6, 4'hd,
      4'h0, 4'h9, 4'h3, 4'he, 4'hb, 4'h4, 4'h2, 4'hc},
    '{4'h5, 4'hd, 4'hf, 4'h6, 4'h9, 4'h2, 4'hc, 4'ha,
      4'hb, 4'h7, 4'h8, 4'h1, 4'h4, 4'h3, 4'he, 4'h0},
    '{4'h8, 4'he, 4'h2, 4'h5, 4'h6, 4'h9, 4'h1, 4'hc,
      4'hf, 4'h4, 4'hb, 4'h0, 4'hd, 4'ha, 4'h3, 4'h7},
    '{4'h1, 4'h7, 4'he, 4'hd, 4'h0, 4'h5, 4'h8, 4'h3,
      4'h4, 4'hf, 4'ha, 4'h6, 4'h9, 4'hc, 4'hb, 4'h2}
  };

  // Subkey index of encryption round r: K1..K8 three times, then K8..K1.
  function automatic logic [KEY_IDX_W-1:0] enc_key_idx(input int r);
    logic [KEY_IDX_W-1:0] low;
    low = KEY_IDX_W'(r);
    if (r < 3 * KEY_WORDS) begin
      return low;
    end
    return KEY_IDX_W'(KEY_WORDS - 1) - low;
  endfunction

  // Key addition, nibble substitution and rotation left by eleven.
  function automatic word_t round_fn(input word_t k, input word_t x);
    word_t s;
    word_t t;
    s = x + k;
    for (int n = 0; n < 8; n++) begin
      t[4*n +: 4] = SBOX[n][s[4*n +: 4]];
    end
    return {t[20:0], t[31:21]};
  endfunction

endpackage

`default_nettype wire

@@ rtl/magma_cell.sv @@
// ----------------------------------------------------------------------------
// Magma round cell
// One Feistel round with its own stage register and transfer handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module magma_cell
  import magma_pkg::*;
#(
  parameter int ROUND = 0
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire key_arr_t key_words,
  input  wire logic     up_valid,
  output logic          up_ready,
  input  wire stage_t   up_data,
  output logic          dn_valid,
  input  wire logic     dn_ready,
  output stage_t        dn_data
);

  localparam logic [KEY_IDX_W-1:0] ENC_IDX = enc_key_idx(ROUND);
  localparam logic [KEY_IDX_W-1:0] DEC_IDX = enc_key_idx(ROUNDS - 1 - ROUND);
  localparam bit                   LAST    = (ROUND == ROUNDS - 1);

  logic   valid_r;
  stage_t data_r;
  stage_t data_nxt;
  word_t  subkey;
  word_t  mixed;

  always_comb begin
    subkey = up_data.action ? key_words[DEC_IDX] : key_words[ENC_IDX];
    mixed  = up_data.a1 ^ round_fn(subkey, up_data.a0);
    data_nxt.action = up_data.action;
    // The final round leaves the halves in place.
    if (LAST) begin
      data_nxt.a1 = mixed;
      data_nxt.a0 = up_data.a0;
    end else begin
      data_nxt.a1 = up_data.a0;
      data_nxt.a0 = mixed;
    end
  end

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/magma_block_cipher.sv @@
// ----------------------------------------------------------------------------
// Magma block cipher, 32-round pipelined engine
// A block passes the round stages in order, one round per stage, and is
// offered as a result from the last stage's register. Throughput is one 64-bit
// block per cycle while results are taken; empty stages close up under stall.
// Synchronous active-low reset empties every stage and clears all key words.
// ----------------------------------------------------------------------------
`default_nettype none

`include "magma_block_cipher_macros.svh"

module magma_block_cipher
  import magma_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [KEY_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_action,
  input  wire logic [63:0]          in_block_in,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [63:0]               out_block_out
);

  // Key words K1..K8, which the user must write through the configuration port
  // while the engine is idle, unenforced here. Each round cell picks its subkey.
  key_arr_t key_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KEY_WORDS; i++) begin
        key_r[i] <= '0;
      end
    end else if (cfg_we) begin
      key_r[cfg_index] <= cfg_wdata;
    end
  end

  // Handshake and payload between neighbouring cells. Entry zero is the
  // input port and the last entry is the result port; the last cell's
  // stage register doubles as the output register.
  logic        stg_valid [ROUNDS+1];
  logic        stg_ready [ROUNDS+1];
  stage_t      stg_data  [ROUNDS+1];

  assign stg_valid[0]       = in_valid;
  assign in_ready           = stg_ready[0];
  assign stg_data[0]        = {in_action, in_block_in[63:32], in_block_in[31:0]};

  // Each cell takes a transfer whenever it is empty or its own content moves
  // on in the same cycle, so bubbles are squeezed out while the result side
  // stalls, and a new block enters every cycle when the result is taken.
  for (genvar r = 0; r < ROUNDS; r++) begin : g_round
    magma_cell #(
      .ROUND (r)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .key_words (key_r),
      .up_valid  (stg_valid[r]),
      .up_ready  (stg_ready[r]),
      .up_data   (stg_data[r]),
      .dn_valid  (stg_valid[r+1]),
      .dn_ready  (stg_ready[r+1]),
      .dn_data   (stg_data[r+1])
    );
  end

  assign out_valid           = stg_valid[ROUNDS];
  assign stg_ready[ROUNDS]   = out_ready;
  assign out_block_out       = {stg_data[ROUNDS].a1, stg_data[ROUNDS].a0};

  // An empty final stage means there is room somewhere, so input is taken.
  `MAGMA_ASSERT_NOW(a_room_when_out_empty, !out_valid, in_ready, "input stalled with no result pending")
  // A result being drained frees the whole chain for a new transfer.
  `MAGMA_ASSERT_NOW(a_ready_follows_out, out_ready, in_ready, "input stalled while result side ready")

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// Magma block cipher testbench
// Drives blocks through the pipelined cipher under several key settings,
// predicts every result from its own model of the 32-round network and
// compares each output transfer with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import magma_pkg::*;

  localparam int PIPE_LATENCY = 32;

  // S-box rows, entry 0 in the most significant nibble of each row.
  localparam logic [0:7][63:0] SUBST = {
    64'hc462a5b9e8d703f1,
    64'h68239a5c1e47bd0f,
    64'hb3582fade174c960,
    64'hc821d4f670a53e9b,
    64'h7f5a816d093eb42c,
    64'h5df692cab78143e0,
    64'h8e25691cf4b0da37,
    64'h17ed05834fa69cb2
  };

  typedef logic [7:0][31:0] key_set_t;

  typedef struct packed {
    logic        action;
    logic [63:0] block_in;
  } block_item_t;

  typedef struct packed {
    logic        action;
    logic [63:0] block_in;
    logic [63:0] block_out;
  } cipher_result_t;

  // Published example from the standard, used to sanity-check the model.
  localparam key_set_t  STD_KEY = {32'hfcfdfeff, 32'hf8f9fafb, 32'hf4f5f6f7, 32'hf0f1f2f3,
                                   32'h33221100, 32'h77665544, 32'hbbaa9988, 32'hffeeddcc};
  localparam logic [63:0] STD_PLAIN  = 64'hfedcba9876543210;
  localparam logic [63:0] STD_CIPHER = 64'h4ee901e5c2d8ca3d;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [KEY_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_action = 1'b0;
  logic [63:0]          in_block_in = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [63:0]          out_block_out;

  magma_block_cipher u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_block_in   (in_block_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_block_out (out_block_out)
  );

  // Blocks waiting to be offered, and predictions waiting for their result.
  block_item_t    pending_blocks [$];
  cipher_result_t expected_results [$];

  key_set_t model_key = '0;
  int error_count = 0;
  int encrypt_count = 0;
  int decrypt_count = 0;
  int checked_count = 0;
  int input_stall_cycles = 0;
  int key_settings = 1;

  // Per-phase knobs for the sender and the receiver.
  int gap_max = 0;
  int rx_mode = 0;
  int pressure_req = 0;

  // One round function: key addition mod 2^32, substitution, rotate left 11.
  function automatic logic [31:0] round_mix(logic [31:0] k, logic [31:0] x);
    logic [31:0] sum;
    logic [31:0] sub;
    int          nib;
    sum = x + k;
    for (int n = 0; n < 8; n++) begin
      nib = int'(sum[4*n +: 4]);
      sub[4*n +: 4] = 4'(SUBST[n] >> (4 * (15 - nib)));
    end
    return {sub[20:0], sub[31:21]};
  endfunction

  // Full 32-round transform. Decryption walks the encryption key schedule
  // backwards; the final round leaves the halves unswapped.
  function automatic logic [63:0] magma_transform(key_set_t keys, logic decrypt,
                                                  logic [63:0] blk);
    logic [31:0] hi;
    logic [31:0] lo;
    logic [31:0] mixed;
    int          kr;
    int          idx;
    hi = blk[63:32];
    lo = blk[31:0];
    for (int r = 0; r < 32; r++) begin
      kr = decrypt ? 31 - r : r;
      idx = (kr < 24) ? kr % 8 : 7 - kr % 8;
      mixed = hi ^ round_mix(keys[idx], lo);
      if (r == 31) begin
        hi = mixed;
      end else begin
        hi = lo;
        lo = mixed;
      end
    end
    return {hi, lo};
  endfunction

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("%0t: timeout with %0d results outstanding", $time, expected_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sender. Offers pending blocks in bursts of random length separated by
  // random gaps. Once valid is raised it is held, with the payload unchanged,
  // until the transfer completes.
  // --------------------------------------------------------------------------
  int          burst_left = 0;
  int          gap_left = 0;
  block_item_t next_item;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else if (!(in_valid && !in_ready)) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_blocks.size() > 0) begin
        next_item = pending_blocks.pop_front();
        in_valid <= 1'b1;
        in_action <= next_item.action;
        in_block_in <= next_item.block_in;
        if (burst_left > 0) begin
          burst_left = burst_left - 1;
        end else begin
          burst_left = $urandom_range(40, 1);
          gap_left = (gap_max == 0) ? 0 : $urandom_range(gap_max, 0);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver. Its stall pattern depends on the phase. When the main sequence
  // asks for pressure, it refuses results for a long stretch so that the
  // pipeline fills and the cipher has to stall its input.
  // --------------------------------------------------------------------------
  int hold_left = 0;
  int pressure_seen = 0;
  int rx_cycle = 0;

  always @(posedge clk) begin
    rx_cycle = rx_cycle + 1;
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left = 0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (pressure_seen != pressure_req) begin
      pressure_seen = pressure_req;
      hold_left = 300;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: begin
          out_ready <= 1'b1;
        end
        1: begin
          out_ready <= 1'($urandom_range(1, 0));
        end
        2: begin
          out_ready <= (rx_cycle % 5 != 0) && (rx_cycle % 7 != 3);
        end
        default: begin
          out_ready <= ($urandom_range(7, 0) != 0);
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. Tracks key writes, predicts a result for every input transfer
  // and checks every output transfer against the oldest prediction.
  // --------------------------------------------------------------------------
  cipher_result_t predicted;
  cipher_result_t oldest;

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) begin
        model_key[cfg_index] = cfg_wdata;
      end
      if (in_valid && !in_ready) begin
        input_stall_cycles = input_stall_cycles + 1;
      end
      if (in_valid && in_ready) begin
        predicted.action = in_action;
        predicted.block_in = in_block_in;
        predicted.block_out = magma_transform(model_key, in_action, in_block_in);
        expected_results.push_back(predicted);
        if (in_action) begin
          decrypt_count = decrypt_count + 1;
        end else begin
          encrypt_count = encrypt_count + 1;
        end
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, got %h", $time, out_block_out);
          error_count = error_count + 1;
        end else begin
          oldest = expected_results.pop_front();
          checked_count = checked_count + 1;
          if (out_block_out !== oldest.block_out) begin
            $display("%0t: block_out mismatch (action %0d, block_in %h): expected %h, got %h",
                     $time, oldest.action, oldest.block_in, oldest.block_out,
                     out_block_out);
            error_count = error_count + 1;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------

  // Key words are only written while the pipeline is empty.
  task automatic load_key(key_set_t keys);
    for (int i = 0; i < KEY_WORDS; i++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_index <= KEY_IDX_W'(i);
      cfg_wdata <= keys[i];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    key_settings = key_settings + 1;
  endtask

  task automatic queue_block(logic action, logic [63:0] blk);
    block_item_t item;
    item.action = action;
    item.block_in = blk;
    pending_blocks.push_back(item);
  endtask

  // Random blocks with some all-zero, all-one, one-hot and one-cold values.
  task automatic queue_random(int count);
    logic [63:0] blk;
    logic [63:0] bit_mask;
    for (int i = 0; i < count; i++) begin
      bit_mask = 64'd1 << $urandom_range(63, 0);
      case ($urandom_range(9, 0))
        0: blk = '0;
        1: blk = '1;
        2: blk = bit_mask;
        3: blk = ~bit_mask;
        default: blk = {$urandom, $urandom};
      endcase
      queue_block(1'($urandom_range(1, 0)), blk);
    end
  endtask

  // Wait until every block has been transferred and every result checked.
  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (pending_blocks.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  key_set_t phase_key;

  initial begin
    if (magma_transform(STD_KEY, 1'b0, STD_PLAIN) !== STD_CIPHER) begin
      $display("%0t: model mismatch on the standard example: expected %h, got %h",
               $time, STD_CIPHER, magma_transform(STD_KEY, 1'b0, STD_PLAIN));
      error_count = error_count + 1;
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Keys straight out of reset are all zero. Extreme and patterned blocks
    // in both directions, with neither side idling.
    gap_max = 0;
    rx_mode = 0;
    for (int i = 0; i < KEY_WORDS; i++) begin
      queue_block(1'b0, (i % 2 == 0) ? 64'h0 : 64'hffffffffffffffff);
    end
    queue_block(1'b1, 64'h0);
    queue_block(1'b1, 64'hffffffffffffffff);
    queue_block(1'b0, 64'haaaaaaaaaaaaaaaa);
    queue_block(1'b1, 64'h5555555555555555);
    queue_block(1'b0, 64'h8000000000000000);
    queue_block(1'b1, 64'h0000000000000001);
    queue_block(1'b0, 64'hffffffff00000000);
    queue_block(1'b1, 64'h00000000ffffffff);
    wait_drained();

    // The standard example key: the known plaintext and ciphertext both ways.
    load_key(STD_KEY);
    gap_max = 3;
    rx_mode = 1;
    queue_block(1'b0, STD_PLAIN);
    queue_block(1'b1, STD_CIPHER);
    queue_block(1'b1, STD_PLAIN);
    queue_block(1'b0, STD_CIPHER);
    queue_block(1'b0, 64'hffffffffffffffff);
    queue_block(1'b1, 64'h0);
    wait_drained();

    // All-ones key, random blocks, periodic receiver stalls.
    load_key('1);
    gap_max = 4;
    rx_mode = 2;
    queue_random(100);
    wait_drained();

    // Random keys with a mix of idling patterns; one phase applies pressure.
    for (int ph = 0; ph < 6; ph++) begin
      for (int i = 0; i < KEY_WORDS; i++) begin
        phase_key[i] = $urandom;
      end
      load_key(phase_key);
      gap_max = (ph == 1) ? 0 : (ph % 4) * 2;
      rx_mode = ph % 4;
      if (ph == 1) begin
        pressure_req = pressure_req + 1;
      end
      queue_random(110);
      wait_drained();
    end

    // Let the pipeline run out so that any stray result is caught.
    repeat (PIPE_LATENCY + 8) @(negedge clk);

    $display("Run covered %0d encrypt and %0d decrypt transfers under %0d key settings,",
             encrypt_count, decrypt_count, key_settings);
    $display("with %0d results checked and %0d cycles of input back-pressure.",
             checked_count, input_stall_cycles);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
